// ----- sv/rsf_pkg.sv -----
// ----------------------------------------------------------------------------
// rsf_pkg: shared types, constants and kernel arithmetic
// Pixel, result and control types plus the per-channel sharpen function
// used by the 3x3 sharpen filter.
// ----------------------------------------------------------------------------
package rsf_pkg;

   // channel and pixel widths
   localparam int CH_W  = 8;
   localparam int PIX_W = 3 * CH_W;

   // position widths
   localparam int ROW_W = 12;
   localparam int COL_W = 10;
   localparam int POS_W = 14;   // wide enough for any line length up to 8192

   // configuration register widths and reset values
   localparam int FW_W       = 11;
   localparam int FH_W       = 13;
   localparam int CSR_DATA_W = 13;
   localparam int CSR_IDX_W  = 1;
   localparam logic [FW_W-1:0] FRAME_WIDTH_RST  = 11'd640;
   localparam logic [FH_W-1:0] FRAME_HEIGHT_RST = 13'd480;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 1'b1;

   // frame size limits
   localparam int MIN_DIM      = 3;
   localparam int MAX_ROWS     = 4096;
   localparam int MAX_LINE_DEF = 1024;

   // line store entry: older line pixel above newer line pixel
   localparam int LINE_W = 2 * PIX_W;

   // kernel center weight and channel ceiling
   localparam int KERN_CENTER = 5;
   localparam logic [CH_W-1:0] CH_MAX = 8'd255;

   // pixel packed as red, green, blue from the top bits down
   typedef logic [PIX_W-1:0] pixel_type;

   typedef struct packed {
      pixel_type          pixel;
      logic [ROW_W-1:0]   row;
      logic [COL_W-1:0]   col;
      logic               frame_end;
   } result_type;

   // results caused by one input word; mask bit 0 is the window result,
   // bit 1 the right column of the line above, bit 2 the bottom row pixel
   typedef struct packed {
      logic [2:0]  mask;
      result_type  res_c;
      result_type  res_b;
      result_type  res_a;
   } bundle_type;

   // per-word control decided when the word enters
   typedef struct packed {
      logic has_a;
      logic interior;
      logic has_b;
      logic has_c;
      logic line_end;
   } item_ctrl_type;

   // 5*mid - up - left - right - down per channel, clamped to 0..255
   function automatic pixel_type sharpen_px(input pixel_type up,
                                            input pixel_type left,
                                            input pixel_type mid,
                                            input pixel_type right,
                                            input pixel_type down);
      pixel_type        res;
      logic [11:0]      acc;
      res = '0;
      for (int s = 0; s < 3; s++) begin
         acc = 12'(KERN_CENTER) * {4'b0, mid[s*CH_W +: CH_W]}
             - {4'b0, up[s*CH_W +: CH_W]}
             - {4'b0, left[s*CH_W +: CH_W]}
             - {4'b0, right[s*CH_W +: CH_W]}
             - {4'b0, down[s*CH_W +: CH_W]};
         if (acc[11]) begin
            res[s*CH_W +: CH_W] = '0;
         end else if (acc > {4'b0, CH_MAX}) begin
            res[s*CH_W +: CH_W] = CH_MAX;
         end else begin
            res[s*CH_W +: CH_W] = acc[CH_W-1:0];
         end
      end
      return res;
   endfunction

endpackage

// ----- sv/rsf_line_store.sv -----
// ----------------------------------------------------------------------------
// rsf_line_store: two-line pixel memory
// One synchronous memory holding the two previous lines side by side,
// one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsf_line_store
   import rsf_pkg::*;
#(
   parameter int DEPTH  = MAX_LINE_DEF,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [LINE_W-1:0] rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [LINE_W-1:0] wr_data
);

   logic [LINE_W-1:0] line_mem [DEPTH];
   logic [LINE_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         line_mem[wr_addr] <= wr_data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= line_mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/rsf_window_stage.sv -----
// ----------------------------------------------------------------------------
// rsf_window_stage: neighborhood window and kernel stage
// Holds one word while its line store read completes, forms its results,
// writes the line store back and shifts the window.
// ----------------------------------------------------------------------------
module rsf_window_stage
   import rsf_pkg::*;
#(
   parameter int ADDR_W = $clog2(MAX_LINE_DEF)
) (
   input  logic              clock,
   input  logic              reset,
   // word entering the stage
   input  logic              load,
   input  pixel_type         in_pixel,
   input  logic [ROW_W-1:0]  in_row,
   input  logic [COL_W-1:0]  in_col,
   input  logic [ADDR_W-1:0] in_idx,
   input  item_ctrl_type     in_ctrl,
   output logic              stage_ready,
   // line store
   input  logic [LINE_W-1:0] rd_data,
   output logic              wr_en,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [LINE_W-1:0] wr_data,
   // result bundle
   input  logic              bundle_free,
   output logic              bundle_load,
   output bundle_type        bundle
);

   logic              valid_ff, valid_in;
   pixel_type         pix_ff;
   logic [ROW_W-1:0]  row_ff;
   logic [COL_W-1:0]  col_ff;
   logic [ADDR_W-1:0] idx_ff;
   item_ctrl_type     ctrl_ff;

   // window: top c-1, middle c-1, middle c-2, bottom c-1
   pixel_type win_top_ff,  win_top_in;
   pixel_type win_mid1_ff, win_mid1_in;
   pixel_type win_mid2_ff, win_mid2_in;
   pixel_type win_bot_ff,  win_bot_in;

   pixel_type rd_top;
   pixel_type rd_mid;
   logic      advance;

   assign rd_top = rd_data[LINE_W-1:PIX_W];
   assign rd_mid = rd_data[PIX_W-1:0];

   // stage handshake
   assign advance     = valid_ff & bundle_free;
   assign stage_ready = ~valid_ff | bundle_free;
   assign bundle_load = advance;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // word payload
   always_ff @(posedge clock) begin
      if (load) begin
         pix_ff  <= in_pixel;
         row_ff  <= in_row;
         col_ff  <= in_col;
         idx_ff  <= in_idx;
         ctrl_ff <= in_ctrl;
      end
   end

   // window shift on advance
   always_comb begin
      win_top_in  = win_top_ff;
      win_mid1_in = win_mid1_ff;
      win_mid2_in = win_mid2_ff;
      win_bot_in  = win_bot_ff;
      if (advance) begin
         win_top_in  = rd_top;
         win_mid1_in = rd_mid;
         win_mid2_in = win_mid1_ff;
         win_bot_in  = pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_top_ff  <= '0;
         win_mid1_ff <= '0;
         win_mid2_ff <= '0;
         win_bot_ff  <= '0;
      end else begin
         win_top_ff  <= win_top_in;
         win_mid1_ff <= win_mid1_in;
         win_mid2_ff <= win_mid2_in;
         win_bot_ff  <= win_bot_in;
      end
   end

   // line store write back: middle line moves up, new pixel becomes middle
   assign wr_en   = advance;
   assign wr_addr = idx_ff;
   assign wr_data = {rd_mid, pix_ff};

   // results of this word
   always_comb begin
      bundle.mask = {ctrl_ff.has_c, ctrl_ff.has_b, ctrl_ff.has_a};

      bundle.res_a.pixel     = ctrl_ff.interior
                             ? sharpen_px(win_top_ff, win_mid2_ff, win_mid1_ff,
                                          rd_mid, win_bot_ff)
                             : win_mid1_ff;
      bundle.res_a.row       = row_ff - 1'b1;
      bundle.res_a.col       = col_ff - 1'b1;
      bundle.res_a.frame_end = 1'b0;

      bundle.res_b.pixel     = rd_mid;
      bundle.res_b.row       = row_ff - 1'b1;
      bundle.res_b.col       = col_ff;
      bundle.res_b.frame_end = 1'b0;

      bundle.res_c.pixel     = pix_ff;
      bundle.res_c.row       = row_ff;
      bundle.res_c.col       = col_ff;
      bundle.res_c.frame_end = ctrl_ff.line_end;
   end

endmodule

// ----- sv/rsf_emitter.sv -----
// ----------------------------------------------------------------------------
// rsf_emitter: result bundle register and output channel
// Holds the results of one word and sends them in order, one per cycle while
// the receiver is ready, marking the last result of each word.
// ----------------------------------------------------------------------------
module rsf_emitter
   import rsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        bundle_load,
   input  bundle_type  bundle,
   output logic        bundle_free,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // red, green, blue, out_row, out_col, zero pad
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,   // frame_end
   output logic [0:0]  rsp_tuser    // run_last
);

   logic [2:0]  mask_ff, mask_in;
   result_type  res_a_ff, res_b_ff, res_c_ff;
   logic [2:0]  low_bit;
   result_type  sel;
   logic        taken;

   // lowest pending result goes first
   assign low_bit = mask_ff & (~mask_ff + 3'd1);
   assign taken   = rsp_tvalid & rsp_tready;

   // free when nothing pends after this cycle
   assign bundle_free = (mask_ff == 3'd0)
                      | (rsp_tready & ((mask_ff & (mask_ff - 3'd1)) == 3'd0));

   always_comb begin
      mask_in = mask_ff;
      if (bundle_load) begin
         mask_in = bundle.mask;
      end else if (taken) begin
         mask_in = mask_ff & ~low_bit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mask_ff <= 3'd0;
      end else begin
         mask_ff <= mask_in;
      end
   end

   // bundle payload
   always_ff @(posedge clock) begin
      if (bundle_load) begin
         res_a_ff <= bundle.res_a;
         res_b_ff <= bundle.res_b;
         res_c_ff <= bundle.res_c;
      end
   end

   // output select
   always_comb begin
      if (low_bit[0]) begin
         sel = res_a_ff;
      end else if (low_bit[1]) begin
         sel = res_b_ff;
      end else begin
         sel = res_c_ff;
      end
   end

   assign rsp_tvalid   = (mask_ff != 3'd0);
   assign rsp_tdata    = {2'b00, sel.col, sel.row,
                          sel.pixel[CH_W-1:0],
                          sel.pixel[2*CH_W-1:CH_W],
                          sel.pixel[PIX_W-1:2*CH_W]};
   assign rsp_tlast    = sel.frame_end;
   assign rsp_tuser[0] = ((mask_ff & ~low_bit) == 3'd0);

endmodule

// ----- sv/rgb_sharpen_3x3_filter.sv -----
// ----------------------------------------------------------------------------
// rgb_sharpen_3x3_filter: streaming 3x3 sharpen filter for RGB pixels
// Raster pixels in, filtered or border pixels out with their own position.
// A taken word is registered in the window stage, then its results in the
// emitter. Throughput: one word per cycle while each word causes at most
// one result and rsp_tready is high; the output port sends one result per
// cycle while ready, so words at line ends and on the last row stall input.
// Reset: position, window and registers return to defaults (640 x 480); the
// line store is not cleared; values read before any write reach no result.
// ----------------------------------------------------------------------------
module rgb_sharpen_3x3_filter
   import rsf_pkg::*;
#(
   parameter int MAX_LINE = MAX_LINE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // pixel input
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // red_in, green_in, blue_in
   // result output
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // red, green, blue, row, col, pad
   output logic                  rsp_tlast,   // frame_end
   output logic [0:0]            rsp_tuser,   // run_last
   // register writes
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   localparam int ADDR_W = $clog2(MAX_LINE);

   logic [FW_W-1:0]   frame_width_ff;
   logic [FH_W-1:0]   frame_height_ff;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [COL_W-1:0]  col_ff, col_in;

   logic [POS_W-1:0]  fw_ext, w_eff, w_last, c_ext;
   logic [FH_W-1:0]   h_eff, h_last, r_ext;
   logic [ADDR_W-1:0] idx;
   item_ctrl_type     ctrl;
   pixel_type         in_pixel;

   logic              stage_ready;
   logic              accept;
   logic [LINE_W-1:0] rd_data;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [LINE_W-1:0] wr_data;
   logic              bundle_free;
   logic              bundle_load;
   bundle_type        bundle;

   // register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= FRAME_WIDTH_RST;
         frame_height_ff <= FRAME_HEIGHT_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_FRAME_WIDTH: begin
               frame_width_ff <= csr_data[FW_W-1:0];
            end
            CSR_FRAME_HEIGHT: begin
               frame_height_ff <= csr_data[FH_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective frame size, saturated to the supported range
   always_comb begin
      fw_ext = POS_W'(frame_width_ff);
      if (fw_ext < POS_W'(MIN_DIM)) begin
         w_eff = POS_W'(MIN_DIM);
      end else if (fw_ext > POS_W'(MAX_LINE)) begin
         w_eff = POS_W'(MAX_LINE);
      end else begin
         w_eff = fw_ext;
      end
      if (frame_height_ff < FH_W'(MIN_DIM)) begin
         h_eff = FH_W'(MIN_DIM);
      end else if (frame_height_ff > FH_W'(MAX_ROWS)) begin
         h_eff = FH_W'(MAX_ROWS);
      end else begin
         h_eff = frame_height_ff;
      end
      w_last = w_eff - 1'b1;
      h_last = h_eff - 1'b1;
   end

   // classify the incoming word by its position
   always_comb begin
      c_ext = POS_W'(col_ff);
      r_ext = FH_W'(row_ff);
      idx   = (c_ext < POS_W'(MAX_LINE)) ? c_ext[ADDR_W-1:0] : ADDR_W'(MAX_LINE - 1);

      ctrl.line_end = (c_ext >= w_last);
      ctrl.has_c    = (r_ext >= h_last);
      ctrl.has_a    = (row_ff != '0) && (col_ff != '0);
      ctrl.has_b    = (row_ff != '0) && ctrl.line_end;
      ctrl.interior = (row_ff >= ROW_W'(2)) && (r_ext < h_eff)
                   && (col_ff >= COL_W'(2)) && (c_ext < w_eff);
   end

   assign in_pixel   = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};
   assign req_tready = stage_ready;
   assign accept     = req_tvalid & stage_ready;

   // raster position of the next word
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (accept) begin
         if (ctrl.line_end) begin
            col_in = '0;
            row_in = ctrl.has_c ? '0 : row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // line store
   rsf_line_store #(
      .DEPTH  (MAX_LINE),
      .ADDR_W (ADDR_W)
   ) u_line_store (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (idx),
      .rd_data (rd_data),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data)
   );

   // window and kernel
   rsf_window_stage #(
      .ADDR_W (ADDR_W)
   ) u_window_stage (
      .clock       (clock),
      .reset       (reset),
      .load        (accept),
      .in_pixel    (in_pixel),
      .in_row      (row_ff),
      .in_col      (col_ff),
      .in_idx      (idx),
      .in_ctrl     (ctrl),
      .stage_ready (stage_ready),
      .rd_data     (rd_data),
      .wr_en       (wr_en),
      .wr_addr     (wr_addr),
      .wr_data     (wr_data),
      .bundle_free (bundle_free),
      .bundle_load (bundle_load),
      .bundle      (bundle)
   );

   // output sequencing
   rsf_emitter u_emitter (
      .clock       (clock),
      .reset       (reset),
      .bundle_load (bundle_load),
      .bundle      (bundle),
      .bundle_free (bundle_free),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .rsp_tuser   (rsp_tuser)
   );

   // frame end result is always the last one of its word
   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rsp_tuser[0])
      else $error("frame end result not last of its word");

   // write back never lands on the entry being read
   a_no_rw_collide: assert property (@(posedge clock) disable iff (reset)
      (wr_en && accept) |-> (wr_addr != idx))
      else $error("line store read and write hit the same entry");

   // a word at the line end restarts the column
   a_line_wrap: assert property (@(posedge clock) disable iff (reset)
      (accept && ctrl.line_end) |=> (col_ff == '0))
      else $error("column did not wrap at line end");

endmodule
